// ----- design/gmsn_pkg.sv -----
`default_nettype none
package gmsn_pkg;

    // Default grid size
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Width of y * MAX_COLS + x before it is cut down to a cell address
    localparam int LIN_W = 17;

    // Configuration register indexes
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // Request opcodes
    typedef enum logic [3:0] {
        OP_QUERY   = 4'd0,
        OP_NBRS    = 4'd1,
        OP_START   = 4'd2,
        OP_GOAL    = 4'd3,
        OP_WALL    = 4'd4,
        OP_WEIGHT  = 4'd5,
        OP_EMPTY   = 4'd6,
        OP_TWALL   = 4'd7,
        OP_TWEIGHT = 4'd8,
        OP_CLEAR   = 4'd9
    } t_op;

    // Reported cell types; wall wins over start, goal and weight
    typedef enum logic [2:0] {
        CT_EMPTY  = 3'd0,
        CT_WALL   = 3'd1,
        CT_START  = 3'd2,
        CT_GOAL   = 3'd3,
        CT_WEIGHT = 3'd4
    } t_cell;

    // Step cost into a neighbour
    localparam logic [2:0] COST_WEIGHT = 3'd5;
    localparam logic [2:0] COST_PLAIN  = 3'd1;

    // Neighbour directions, in listing order
    localparam logic [1:0] DIR_E = 2'd0;
    localparam logic [1:0] DIR_W = 2'd1;
    localparam logic [1:0] DIR_N = 2'd2;
    localparam logic [1:0] DIR_S = 2'd3;

    // Classified request, front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       inb;     // requested cell inside the grid in use
        logic [3:0] nb_inb;  // per direction: neighbour inside the grid in use
    } t_cmd;

    // Back-end status towards the input side
    typedef struct packed {
        logic clearing;
    } t_bstat;

endpackage
`default_nettype wire

// ----- design/gmsn_fifo.sv -----
`default_nettype none
module gmsn_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule
`default_nettype wire

// ----- design/gmsn_front.sv -----
`default_nettype none
module gmsn_front
    import gmsn_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int AW = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [15:0]   s_axis_tdata,   // pos_x, pos_y
    input  wire logic [3:0]    s_axis_tuser,   // opcode
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [6:0]    i_cfg_data,
    input  wire t_bstat        i_stat,
    input  wire logic          i_full,
    output logic               o_push,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_base
);

    localparam logic [6:0] CFG_RESET = 7'd64;

    logic [6:0] r_cols;
    logic [6:0] r_rows;

    logic [8:0]       w_cols;
    logic [8:0]       w_rows;
    logic [8:0]       w_x;
    logic [8:0]       w_y;
    logic             w_xin;
    logic             w_yin;
    logic [LIN_W-1:0] w_lin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_RESET;
            r_rows <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // register values above the physical grid saturate
    assign w_cols = (9'(r_cols) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(r_cols);
    assign w_rows = (9'(r_rows) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(r_rows);

    assign w_x   = 9'(s_axis_tdata[7:0]);
    assign w_y   = 9'(s_axis_tdata[15:8]);
    assign w_xin = (w_x < w_cols);
    assign w_yin = (w_y < w_rows);

    assign w_lin = LIN_W'(w_y) * LIN_W'(MAX_COLS) + LIN_W'(w_x);

    assign s_axis_tready = !i_full && !i_stat.clearing;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = t_op'(s_axis_tuser);
        o_cmd.pos_x  = s_axis_tdata[7:0];
        o_cmd.pos_y  = s_axis_tdata[15:8];
        o_cmd.inb    = w_xin && w_yin;
        o_cmd.nb_inb[DIR_E] = w_yin && ((w_x + 9'd1) < w_cols);
        o_cmd.nb_inb[DIR_W] = w_yin && (w_x != 9'd0) && (w_x <= w_cols);
        o_cmd.nb_inb[DIR_N] = w_xin && (w_y != 9'd0) && (w_y <= w_rows);
        o_cmd.nb_inb[DIR_S] = w_xin && ((w_y + 9'd1) < w_rows);
    end

    // only meaningful when the cell or one of its neighbours is in the grid
    assign o_base = w_lin[AW-1:0];

endmodule
`default_nettype wire

// ----- design/gmsn_back.sv -----
`default_nettype none
module gmsn_back
    import gmsn_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int AW = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_base,
    output logic               o_pop,
    output t_bstat             o_stat,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // ok, cell_type, nbr_x, nbr_y, nbr_cost
    output logic               m_axis_tuser,   // nbr_valid
    output logic               m_axis_tlast
);

    localparam int            DEPTH     = MAX_COLS * MAX_ROWS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_COLS);

    typedef struct packed {
        logic       ok;
        t_cell      cell_type;
        logic       nbr_valid;
        logic [5:0] nbr_x;
        logic [5:0] nbr_y;
        logic [2:0] nbr_cost;
        logic       last;
    } t_res;

    typedef enum logic [7:0] {
        ST_SWEEP = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_EXEC  = 8'b0000_1000,
        ST_NRD   = 8'b0001_0000,
        ST_NLAST = 8'b0010_0000,
        ST_NOUT  = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } t_state;

    // cell store: bit 0 wall, bit 1 weight
    logic [1:0] r_mem [DEPTH];

    t_state        r_state,   n_state;
    logic [AW-1:0] r_cnt,     n_cnt;
    logic          r_clr_rsp, n_clr_rsp;
    t_cmd          r_cmd,     n_cmd;
    logic [AW-1:0] r_base,    n_base;
    logic [AW-1:0] r_start,   n_start;
    logic [AW-1:0] r_goal,    n_goal;
    logic          r_pend,    n_pend;
    logic [1:0]    r_pdir,    n_pdir;
    logic [1:0]    r_dir,     n_dir;
    logic [3:0]    r_pass,    n_pass;
    logic [3:0]    r_wt,      n_wt;
    t_res          r_res,     n_res;
    logic [1:0]    r_rdata;
    logic          r_ovalid;
    t_res          r_ores;

    logic               w_out_free;
    logic               w_emit;
    t_res               w_emit_res;
    logic               w_mem_we;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_addr;
    logic [1:0]         w_mem_wdata;
    logic [3:0][AW-1:0] w_nbr_addr;
    logic [3:0][5:0]    w_nbr_x;
    logic [3:0][5:0]    w_nbr_y;
    logic               w_rev;
    logic [1:0]         w_pick;
    logic [3:0]         w_rest;
    t_cell              w_ntype;
    t_cell              w_qtype;
    logic               w_sg;

    assign w_out_free = !r_ovalid || m_axis_tready;

    assign w_nbr_addr[DIR_E] = r_base + AW'(1);
    assign w_nbr_addr[DIR_W] = r_base - AW'(1);
    assign w_nbr_addr[DIR_N] = r_base - ROW_STEP;
    assign w_nbr_addr[DIR_S] = r_base + ROW_STEP;

    assign w_nbr_x[DIR_E] = 6'(r_cmd.pos_x + 8'd1);
    assign w_nbr_x[DIR_W] = 6'(r_cmd.pos_x - 8'd1);
    assign w_nbr_x[DIR_N] = r_cmd.pos_x[5:0];
    assign w_nbr_x[DIR_S] = r_cmd.pos_x[5:0];
    assign w_nbr_y[DIR_E] = r_cmd.pos_y[5:0];
    assign w_nbr_y[DIR_W] = r_cmd.pos_y[5:0];
    assign w_nbr_y[DIR_N] = 6'(r_cmd.pos_y - 8'd1);
    assign w_nbr_y[DIR_S] = 6'(r_cmd.pos_y + 8'd1);

    // even x+y lists south first
    assign w_rev = ~(r_cmd.pos_x[0] ^ r_cmd.pos_y[0]);

    always_comb begin
        logic found;
        found  = 1'b0;
        w_pick = DIR_E;
        for (int k = 0; k < 4; k++) begin
            if (w_rev) begin
                if (!found && r_pass[3 - k]) begin
                    w_pick = 2'(3 - k);
                    found  = 1'b1;
                end
            end else begin
                if (!found && r_pass[k]) begin
                    w_pick = 2'(k);
                    found  = 1'b1;
                end
            end
        end
    end

    assign w_rest = r_pass & ~(4'b0001 << w_pick);

    always_comb begin
        if (w_nbr_addr[w_pick] == r_start)     w_ntype = CT_START;
        else if (w_nbr_addr[w_pick] == r_goal) w_ntype = CT_GOAL;
        else if (r_wt[w_pick])                 w_ntype = CT_WEIGHT;
        else                                   w_ntype = CT_EMPTY;
    end

    always_comb begin
        if (r_rdata[0])            w_qtype = CT_WALL;
        else if (r_base == r_start) w_qtype = CT_START;
        else if (r_base == r_goal)  w_qtype = CT_GOAL;
        else if (r_rdata[1])        w_qtype = CT_WEIGHT;
        else                        w_qtype = CT_EMPTY;
    end

    assign w_sg = i_cmd.inb && ((i_base == r_start) || (i_base == r_goal));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_clr_rsp = r_clr_rsp;
        n_cmd     = r_cmd;
        n_base    = r_base;
        n_start   = r_start;
        n_goal    = r_goal;
        n_pend    = 1'b0;
        n_pdir    = r_pdir;
        n_dir     = r_dir;
        n_pass    = r_pass;
        n_wt      = r_wt;
        n_res     = r_res;

        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_emit_res  = r_res;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_base;
        w_mem_wdata = 2'b00;

        // neighbour read issued last cycle lands now
        if (r_pend) begin
            n_pass[r_pdir] = ~r_rdata[0];
            n_wt[r_pdir]   = r_rdata[1];
        end

        case (r_state)
            ST_SWEEP: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_cnt;
                n_cnt      = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt     = '0;
                    n_clr_rsp = 1'b0;
                    n_state   = r_clr_rsp ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_cmd;
                    n_base     = i_base;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    case (i_cmd.op)
                        OP_QUERY, OP_START, OP_GOAL, OP_WEIGHT, OP_EMPTY, OP_TWEIGHT: begin
                            n_state = i_cmd.inb ? ST_READ : ST_RESP;
                        end
                        OP_WALL, OP_TWALL: begin
                            n_state = (i_cmd.inb && !w_sg) ? ST_READ : ST_RESP;
                        end
                        OP_NBRS: begin
                            n_dir   = DIR_E;
                            n_pass  = 4'b0000;
                            n_wt    = 4'b0000;
                            n_state = ST_NRD;
                        end
                        OP_CLEAR: begin
                            n_res.ok  = 1'b1;
                            n_clr_rsp = 1'b1;
                            n_cnt     = '0;
                            n_state   = ST_SWEEP;
                        end
                        default: n_state = ST_RESP;
                    endcase
                end
            end
            ST_READ: begin
                w_mem_re = 1'b1;
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                n_res.ok = 1'b1;
                n_state  = ST_RESP;
                case (r_cmd.op)
                    OP_QUERY: n_res.cell_type = w_qtype;
                    OP_START, OP_GOAL, OP_EMPTY: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = {r_rdata[0] & r_rdata[1], 1'b0};
                        if (r_cmd.op == OP_START) n_start = r_base;
                        if (r_cmd.op == OP_GOAL) n_goal = r_base;
                    end
                    OP_WALL: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = {r_rdata[1], 1'b1};
                    end
                    OP_WEIGHT: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = {1'b1, r_rdata[0]};
                    end
                    OP_TWALL: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = r_rdata[0] ? {r_rdata[1], 1'b0} : 2'b01;
                    end
                    OP_TWEIGHT: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = r_rdata[1] ? {1'b0, r_rdata[0]} : 2'b10;
                    end
                    default: ;
                endcase
            end
            ST_NRD: begin
                if (r_cmd.nb_inb[r_dir]) begin
                    w_mem_re   = 1'b1;
                    w_mem_addr = w_nbr_addr[r_dir];
                end
                n_pend = r_cmd.nb_inb[r_dir];
                n_pdir = r_dir;
                n_dir  = r_dir + 2'd1;
                if (r_dir == DIR_S) n_state = ST_NLAST;
            end
            ST_NLAST: n_state = ST_NOUT;
            ST_NOUT: begin
                if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_res    = '0;
                    w_emit_res.ok = r_cmd.inb;
                    if (r_pass == 4'b0000) begin
                        w_emit_res.last = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        w_emit_res.cell_type = w_ntype;
                        w_emit_res.nbr_valid = 1'b1;
                        w_emit_res.nbr_x     = w_nbr_x[w_pick];
                        w_emit_res.nbr_y     = w_nbr_y[w_pick];
                        w_emit_res.nbr_cost  = r_wt[w_pick] ? COST_WEIGHT : COST_PLAIN;
                        w_emit_res.last      = (w_rest == 4'b0000);
                        n_pass               = w_rest;
                        if (w_rest == 4'b0000) n_state = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_cnt     <= '0;
            r_clr_rsp <= 1'b0;
            r_start   <= '0;
            r_goal    <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_clr_rsp <= n_clr_rsp;
            r_start   <= n_start;
            r_goal    <= n_goal;
            r_pend    <= n_pend;
            if (w_emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_base <= n_base;
        r_pdir <= n_pdir;
        r_dir  <= n_dir;
        r_pass <= n_pass;
        r_wt   <= n_wt;
        r_res  <= n_res;
        if (w_emit) r_ores <= w_emit_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= w_mem_wdata;
        if (w_mem_re) r_rdata <= r_mem[w_mem_addr];
    end

    assign o_stat.clearing = (r_state == ST_SWEEP);

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_ores.nbr_cost, r_ores.nbr_y, r_ores.nbr_x,
                            r_ores.cell_type, r_ores.ok};
    assign m_axis_tuser  = r_ores.nbr_valid;
    assign m_axis_tlast  = r_ores.last;

    a_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("cell store read and written in one cycle");

    a_nbr_passable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ores.nbr_valid) |-> (r_ores.cell_type != CT_WALL))
        else $error("wall cell listed as neighbour");

    a_nbr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NOUT && w_emit && w_emit_res.last) |=> (r_state == ST_IDLE))
        else $error("neighbour listing did not finish on last result");

    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (!w_emit && !o_pop))
        else $error("activity during clearing pass");

endmodule
`default_nettype wire

// ----- design/grid_map_store_with_neighbors_unit.sv -----
// Grid map store with neighbour lister.
// Requests enter on s_axis: tuser = opcode, tdata = {pos_y, pos_x}. Results leave on
// m_axis: tdata = {nbr_cost, nbr_y, nbr_x, cell_type, ok}, tuser = nbr_valid,
// tlast marks the final result of a request. Write the grid size in use on the
// cfg channel (index 0 columns, index 1 rows) only while the unit is idle.
// A front end classifies each request (bounds of the cell and of its four
// neighbours, cell address) and queues it in a two-entry FIFO; a back end owns
// the single-port cell store and runs one request at a time.
// In the back end an in-bounds query or accepted edit runs pop, read, update and
// result; an out-of-bounds, rejected or unknown request runs pop and result. A
// neighbour listing runs pop, four sequential reads of the single store port, a
// wait for the last read to land, then its results in turn. Clear walks the whole
// store, MAX_COLS*MAX_ROWS cells, before its result. After reset the same clearing
// pass runs with s_axis_tready low; cfg writes are taken throughout, and the block
// itself does not enforce the idle rule for them.
// A stalled receiver holds the result register; the back end waits, the FIFO
// fills and s_axis_tready drops.
`default_nettype none
module grid_map_store_with_neighbors_unit
    import gmsn_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // pos_x, pos_y
    input  wire logic [3:0]  s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // ok, cell_type, nbr_x, nbr_y, nbr_cost
    output logic             m_axis_tuser,   // nbr_valid
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_COLS * MAX_ROWS);
    localparam int CW = $bits(t_cmd);
    localparam int QW = CW + AW;

    t_cmd          w_f_cmd;
    logic [AW-1:0] w_f_base;
    logic          w_push;
    logic          w_full;
    logic          w_empty;
    logic          w_pop;
    logic [QW-1:0] w_q_out;
    t_bstat        w_stat;

    gmsn_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stat        (w_stat),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_f_cmd),
        .o_base        (w_f_base)
    );

    gmsn_fifo #(
        .W(QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_base, w_f_cmd}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    gmsn_back #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_cmd         (t_cmd'(w_q_out[CW-1:0])),
        .i_base        (w_q_out[QW-1:CW]),
        .o_pop         (w_pop),
        .o_stat        (w_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
module tb;
    import gmsn_pkg::*;

    localparam int MAXC = DEF_MAX_COLS;
    localparam int MAXR = DEF_MAX_ROWS;
    localparam int CELLS = MAXC * MAXR;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_PHASES = 7;

    // an opcode outside the defined set
    localparam logic [3:0] OP_UNKNOWN = 4'hF;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] x;
        logic [7:0] y;
    } grid_req_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] kind;
        logic       nv;
        logic [5:0] nx;
        logic [5:0] ny;
        logic [2:0] cost;
        logic       last;
    } grid_reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [6:0]  i_cfg_data = '0;

    grid_map_store_with_neighbors_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // grid model
    bit         wall_map[CELLS];
    bit         weight_map[CELLS];
    int         start_idx = 0;
    int         goal_idx = 0;
    logic [6:0] grid_cols = 7'd64;
    logic [6:0] grid_rows = 7'd64;

    grid_req_t   request_q[$];
    grid_reply_t reply_q[$];

    int err_cnt = 0;
    int req_cnt = 0;
    int res_cnt = 0;
    int cyc = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_arm = 0;
    bit hold_used = 0;
    int hold_left = 0;

    int cols_set[N_PHASES] = '{8, 1, 127, 0, 3, 64, 16};
    int rows_set[N_PHASES] = '{8, 1, 5, 64, 64, 64, 127};
    int reqs_set[N_PHASES] = '{70, 15, 70, 15, 70, 80, 80};

    function automatic int eff_size(input logic [6:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic bit cell_in_grid(input int x, input int y);
        return x >= 0 && x < eff_size(grid_cols, MAXC) &&
               y >= 0 && y < eff_size(grid_rows, MAXR);
    endfunction

    function automatic logic [2:0] kind_of(input int idx);
        if (wall_map[idx]) return CT_WALL;
        if (idx == start_idx) return CT_START;
        if (idx == goal_idx) return CT_GOAL;
        if (weight_map[idx]) return CT_WEIGHT;
        return CT_EMPTY;
    endfunction

    // wall goes first; only a wall-free cell loses its weight
    function automatic void clear_one(input int idx);
        if (wall_map[idx]) wall_map[idx] = 0;
        else weight_map[idx] = 0;
    endfunction

    task automatic predict_grid_reply(input logic [3:0] op, input int x, input int y);
        bit          inb;
        bit          sg;
        bit          ok;
        int          idx;
        int          nx[4];
        int          ny[4];
        int          n;
        int          s;
        int          j;
        int          ax;
        int          ay;
        grid_reply_t rep;
        inb = cell_in_grid(x, y);
        idx = inb ? y * MAXC + x : 0;
        sg = inb && (idx == start_idx || idx == goal_idx);
        ok = 0;
        rep = '0;
        rep.last = 1'b1;
        if (op == OP_QUERY) begin
            rep.ok = inb;
            rep.kind = inb ? kind_of(idx) : CT_EMPTY;
            reply_q.insert(reply_q.size(), rep);
        end else if (op == OP_NBRS) begin
            n = 0;
            for (int k = 0; k < 4; k++) begin
                ax = x;
                ay = y;
                case (2'(k))
                    DIR_E: ax = x + 1;
                    DIR_W: ax = x - 1;
                    DIR_N: ay = y - 1;
                    DIR_S: ay = y + 1;
                    default: ;
                endcase
                if (cell_in_grid(ax, ay) && !wall_map[ay * MAXC + ax]) begin
                    nx[n] = ax;
                    ny[n] = ay;
                    n++;
                end
            end
            if (n == 0) begin
                rep.ok = inb;
                reply_q.insert(reply_q.size(), rep);
            end
            for (int k = 0; k < n; k++) begin
                // even x+y lists south first
                s = ((x + y) % 2 == 0) ? n - 1 - k : k;
                j = ny[s] * MAXC + nx[s];
                rep.ok = inb;
                rep.kind = kind_of(j);
                rep.nv = 1'b1;
                rep.nx = 6'(nx[s]);
                rep.ny = 6'(ny[s]);
                rep.cost = weight_map[j] ? COST_WEIGHT : COST_PLAIN;
                rep.last = (k == n - 1);
                reply_q.insert(reply_q.size(), rep);
            end
        end else begin
            case (op)
                OP_START, OP_GOAL: if (inb) begin
                    clear_one(idx);
                    if (op == OP_START) start_idx = idx;
                    else goal_idx = idx;
                    ok = 1;
                end
                OP_WALL: if (inb && !sg) begin
                    wall_map[idx] = 1;
                    ok = 1;
                end
                OP_WEIGHT: if (inb) begin
                    weight_map[idx] = 1;
                    ok = 1;
                end
                OP_EMPTY: if (inb) begin
                    clear_one(idx);
                    ok = 1;
                end
                OP_TWALL: if (inb && !sg) begin
                    if (wall_map[idx]) begin
                        wall_map[idx] = 0;
                    end else begin
                        weight_map[idx] = 0;
                        wall_map[idx] = 1;
                    end
                    ok = 1;
                end
                OP_TWEIGHT: if (inb) begin
                    if (weight_map[idx]) begin
                        weight_map[idx] = 0;
                    end else begin
                        wall_map[idx] = 0;
                        weight_map[idx] = 1;
                    end
                    ok = 1;
                end
                OP_CLEAR: begin
                    foreach (wall_map[c]) begin
                        wall_map[c] = 0;
                        weight_map[c] = 0;
                    end
                    ok = 1;
                end
                default: ok = 0;
            endcase
            rep.ok = ok;
            reply_q.insert(reply_q.size(), rep);
        end
    endtask

    task automatic add_req(input logic [3:0] op, input int x, input int y);
        grid_req_t r;
        r.op = op;
        r.x = 8'(x);
        r.y = 8'(y);
        request_q.insert(request_q.size(), r);
    endtask

    // mostly inside the grid, some on its edge, some anywhere in the field range
    function automatic int pick_axis(input int span);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 60 && span > 0) return $urandom_range(span - 1, 0);
        if (r < 80) begin
            v = span - 1 + $urandom_range(2, 0);
            return (v < 0) ? 0 : v;
        end
        return $urandom_range(255, 0);
    endfunction

    task automatic gen_random_reqs(input int count);
        int         r;
        int         x;
        int         y;
        int         spot;
        logic [3:0] op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(999);
            if (r < 150) op = OP_QUERY;
            else if (r < 400) op = OP_NBRS;
            else if (r < 440) op = OP_START;
            else if (r < 480) op = OP_GOAL;
            else if (r < 640) op = OP_WALL;
            else if (r < 740) op = OP_WEIGHT;
            else if (r < 800) op = OP_EMPTY;
            else if (r < 870) op = OP_TWALL;
            else if (r < 940) op = OP_TWEIGHT;
            else if (r < 950) op = OP_CLEAR;
            else op = 4'($urandom_range(15, int'(OP_CLEAR) + 1));
            if ($urandom_range(9) == 0) begin
                // aim at start or goal to hit the rejection paths
                spot = $urandom_range(1) ? start_idx : goal_idx;
                x = spot % MAXC;
                y = spot / MAXC;
            end else begin
                x = pick_axis(eff_size(grid_cols, MAXC));
                y = pick_axis(eff_size(grid_rows, MAXR));
            end
            add_req(op, x, y);
        end
    endtask

    task automatic write_grid_reg(input logic idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_COLS) grid_cols = val;
        else grid_rows = val;
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : req_driver
        grid_req_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_grid_reply(s_axis_tuser, int'(s_axis_tdata[7:0]),
                                   int'(s_axis_tdata[15:8]));
                req_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {nxt.y, nxt.x};
                    s_axis_tuser <= nxt.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver stall, so the FIFO fills and tready drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : reply_monitor
        grid_reply_t got;
        grid_reply_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ok = m_axis_tdata[0];
                got.kind = m_axis_tdata[3:1];
                got.nx = m_axis_tdata[9:4];
                got.ny = m_axis_tdata[15:10];
                got.cost = m_axis_tdata[18:16];
                got.nv = m_axis_tuser;
                got.last = m_axis_tlast;
                res_cnt++;
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time, got);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("cell_type", want.kind, got.kind);
                    check_field("nbr_valid", want.nv, got.nv);
                    check_field("nbr_x", want.nx, got.nx);
                    check_field("nbr_y", want.ny, got.ny);
                    check_field("nbr_cost", want.cost, got.cost);
                    check_field("last", want.last, got.last);
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        tx_idle_pct = 11;
        rx_idle_pct = 47;
        // directed pass on the reset grid; start and goal both sit on 0,0
        add_req(OP_QUERY, 0, 0);
        add_req(OP_NBRS, 0, 0);
        add_req(OP_WALL, 0, 0);
        add_req(OP_WALL, 1, 0);
        add_req(OP_WEIGHT, 0, 1);
        add_req(OP_NBRS, 0, 0);
        add_req(OP_NBRS, 1, 1);
        add_req(OP_GOAL, 63, 63);
        add_req(OP_QUERY, 63, 63);
        add_req(OP_NBRS, 63, 63);
        add_req(OP_TWALL, 63, 63);
        add_req(OP_START, 255, 255);
        add_req(OP_NBRS, 64, 0);
        add_req(OP_NBRS, 255, 255);
        add_req(OP_TWALL, 2, 2);
        add_req(OP_TWEIGHT, 2, 2);
        add_req(OP_TWALL, 2, 2);
        add_req(OP_WEIGHT, 2, 2);
        add_req(OP_QUERY, 2, 2);
        add_req(OP_EMPTY, 2, 2);
        add_req(OP_QUERY, 2, 2);
        add_req(OP_START, 0, 1);
        add_req(OP_UNKNOWN, 170, 85);
        add_req(OP_CLEAR, 0, 0);
        add_req(OP_QUERY, 1, 0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            repeat (4) @(posedge i_clk);
            write_grid_reg(CFG_COLS, 7'(cols_set[p]));
            write_grid_reg(CFG_ROWS, 7'(rows_set[p]));
            @(negedge i_clk);
            if (p < 2) begin
                tx_idle_pct = 11;
                rx_idle_pct = 47;
            end else if (p < 4) begin
                tx_idle_pct = 47;
                rx_idle_pct = 11;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 4) hold_arm = 1;
            gen_random_reqs(reqs_set[p]);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (reply_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, reply_q.size());
            err_cnt++;
        end
        $display("%0d requests, %0d results checked across %0d grid sizes incl. 0 and 127",
                 req_cnt, res_cnt, N_PHASES + 1);
        $display("idle mixes on both sides and one %0d-cycle receiver stall", HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
